// ===== rtl/fsme_pkg.sv =====
package fsme_pkg;

  // Table sizes and field widths
  localparam int MAX_STATES      = 16;
  localparam int MAX_TRANSITIONS = 64;
  localparam int ID_BITS         = 8;
  localparam int SYMBOL_BITS     = 8;
  localparam int OP_BITS         = 3;
  localparam int STS_BITS        = 2;

  localparam int ST_IDX_W = $clog2(MAX_STATES);
  localparam int ST_CNT_W = $clog2(MAX_STATES + 1);
  localparam int TR_IDX_W = $clog2(MAX_TRANSITIONS);
  localparam int TR_CNT_W = $clog2(MAX_TRANSITIONS + 1);

  // Command opcodes
  localparam logic [OP_BITS-1:0] OP_ADD_NONFINAL = 3'd0;
  localparam logic [OP_BITS-1:0] OP_ADD_FINAL    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_ADD_START    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ADD_TRANS    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_RESET        = 3'd4;
  localparam logic [OP_BITS-1:0] OP_RUN          = 3'd5;

  // Result status codes
  localparam logic [STS_BITS-1:0] STS_OK      = 2'd0;
  localparam logic [STS_BITS-1:0] STS_FINAL   = 2'd1;
  localparam logic [STS_BITS-1:0] STS_NOTRANS = 2'd2;
  localparam logic [STS_BITS-1:0] STS_ERROR   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_st;
    logic scan_tr;
    logic rd_dest;
    logic apply;
    logic emit;
  } fsme_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               start_valid;
    logic               scan_done;
    logic               tr_done;
    logic               tr_hit;
  } fsme_sts_t;

endpackage

// ===== rtl/fsme_ctrl.sv =====
module fsme_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fsme_pkg::fsme_sts_t sts_i,
  output fsme_pkg::fsme_cmd_t cmd_o
);
  import fsme_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;
  localparam logic [2:0] S_SCAN_ST = 3'd2;
  localparam logic [2:0] S_SCAN_TR = 3'd3;
  localparam logic [2:0] S_RD_DEST = 3'd4;
  localparam logic [2:0] S_APPLY   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence one command through lookup, commit and result hand-off
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.op)
          OP_ADD_NONFINAL, OP_ADD_FINAL, OP_ADD_START, OP_ADD_TRANS: state_d = S_SCAN_ST;
          OP_RUN:  state_d = sts_i.start_valid ? S_SCAN_TR : S_APPLY;
          default: state_d = S_APPLY;
        endcase
      end
      S_SCAN_ST: begin
        cmd_o.scan_st = 1'b1;
        if (sts_i.scan_done) state_d = S_APPLY;
      end
      S_SCAN_TR: begin
        cmd_o.scan_tr = 1'b1;
        if (sts_i.tr_done) state_d = sts_i.tr_hit ? S_RD_DEST : S_APPLY;
      end
      S_RD_DEST: begin
        cmd_o.rd_dest = 1'b1;
        state_d       = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Raise valid on a new result, drop it once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/fsme_dpath.sv =====
module fsme_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [fsme_pkg::OP_BITS-1:0]        opcode_i,
  input  logic [fsme_pkg::ID_BITS-1:0]        state_id_i,
  input  logic [fsme_pkg::SYMBOL_BITS-1:0]    input_symbol_i,
  input  logic [fsme_pkg::ID_BITS-1:0]        dest_id_i,
  input  fsme_pkg::fsme_cmd_t                 cmd_i,
  output fsme_pkg::fsme_sts_t                 sts_o,
  output logic [fsme_pkg::STS_BITS-1:0]       status_o,
  output logic [fsme_pkg::ID_BITS-1:0]        next_id_o
);
  import fsme_pkg::*;

  // State table and transition table
  logic [ID_BITS-1:0]     st_id_mem  [MAX_STATES];
  logic                   st_fin_mem [MAX_STATES];
  logic [ST_IDX_W-1:0]    tr_src_mem [MAX_TRANSITIONS];
  logic [SYMBOL_BITS-1:0] tr_sym_mem [MAX_TRANSITIONS];
  logic [ST_IDX_W-1:0]    tr_dst_mem [MAX_TRANSITIONS];

  logic [ID_BITS-1:0]     st_id_rd_q;
  logic                   st_fin_rd_q;
  logic [ST_IDX_W-1:0]    tr_src_rd_q;
  logic [SYMBOL_BITS-1:0] tr_sym_rd_q;
  logic [ST_IDX_W-1:0]    tr_dst_rd_q;

  // Latched command fields
  logic [OP_BITS-1:0]     op_q;
  logic [ID_BITS-1:0]     id_q;
  logic [SYMBOL_BITS-1:0] sym_q;
  logic [ID_BITS-1:0]     dst_q;

  // Machine state
  logic [ST_CNT_W-1:0] states_used_q, states_used_d;
  logic [TR_CNT_W-1:0] trans_used_q, trans_used_d;
  logic [ST_IDX_W-1:0] start_idx_q, start_idx_d;
  logic                start_valid_q, start_valid_d;
  logic [ST_IDX_W-1:0] cur_idx_q, cur_idx_d;

  // Scan bookkeeping
  logic [ST_CNT_W-1:0] sc_q, sc_d;
  logic [TR_CNT_W-1:0] tc_q, tc_d;
  logic [TR_CNT_W-1:0] tc_m1;
  logic                p_valid_q, p_valid_d;
  logic [ST_IDX_W-1:0] p_idx_q, p_idx_d;
  logic                src_hit_q, src_hit_d;
  logic [ST_IDX_W-1:0] src_idx_q, src_idx_d;
  logic                dst_hit_q, dst_hit_d;
  logic [ST_IDX_W-1:0] dst_idx_q, dst_idx_d;
  logic                tr_hit_q, tr_hit_d;
  logic [ST_IDX_W-1:0] hit_dst_q, hit_dst_d;

  // Result registers
  logic [STS_BITS-1:0] res_status_q, res_status_d;
  logic [ID_BITS-1:0]  res_next_q, res_next_d;
  logic [STS_BITS-1:0] out_status_q;
  logic [ID_BITS-1:0]  out_next_q;

  // Memory ports
  logic [ST_IDX_W-1:0] st_raddr;
  logic [TR_IDX_W-1:0] tr_raddr;
  logic                st_we, st_we_fin;
  logic                tr_we;
  logic                st_issue, tr_issue;

  assign tc_m1    = tc_q - TR_CNT_W'(1);
  assign tr_raddr = tc_m1[TR_IDX_W-1:0];
  assign st_raddr = cmd_i.rd_dest ? hit_dst_q : sc_q[ST_IDX_W-1:0];
  assign st_issue = cmd_i.scan_st && (sc_q != states_used_q);
  assign tr_issue = cmd_i.scan_tr && (tc_q != '0) && !tr_hit_q;

  assign sts_o.op          = op_q;
  assign sts_o.start_valid = start_valid_q;
  assign sts_o.scan_done   = (sc_q == states_used_q) && !p_valid_q;
  assign sts_o.tr_done     = tr_hit_q || ((tc_q == '0) && !p_valid_q);
  assign sts_o.tr_hit      = tr_hit_q;

  assign status_o  = out_status_q;
  assign next_id_o = out_next_q;

  // Walk the tables one entry per cycle, comparing each entry in the cycle after its read
  always_comb begin
    sc_d      = sc_q;
    tc_d      = tc_q;
    p_valid_d = p_valid_q;
    p_idx_d   = p_idx_q;
    src_hit_d = src_hit_q;
    src_idx_d = src_idx_q;
    dst_hit_d = dst_hit_q;
    dst_idx_d = dst_idx_q;
    tr_hit_d  = tr_hit_q;
    hit_dst_d = hit_dst_q;
    if (cmd_i.load) begin
      sc_d      = '0;
      tc_d      = trans_used_q;
      p_valid_d = 1'b0;
      src_hit_d = 1'b0;
      dst_hit_d = 1'b0;
      tr_hit_d  = 1'b0;
    end else if (cmd_i.scan_st) begin
      p_valid_d = st_issue;
      p_idx_d   = sc_q[ST_IDX_W-1:0];
      if (st_issue) sc_d = sc_q + ST_CNT_W'(1);
      if (p_valid_q && !src_hit_q && (st_id_rd_q == id_q)) begin
        src_hit_d = 1'b1;
        src_idx_d = p_idx_q;
      end
      if (p_valid_q && !dst_hit_q && (st_id_rd_q == dst_q)) begin
        dst_hit_d = 1'b1;
        dst_idx_d = p_idx_q;
      end
    end else if (cmd_i.scan_tr) begin
      // Newest entry first: count down from the fill level
      p_valid_d = tr_issue;
      if (tr_issue) tc_d = tc_m1;
      if (p_valid_q && !tr_hit_q && (tr_src_rd_q == cur_idx_q) &&
          (tr_sym_rd_q == sym_q)) begin
        tr_hit_d  = 1'b1;
        hit_dst_d = tr_dst_rd_q;
      end
    end
  end

  // Commit the command and form its result
  always_comb begin
    states_used_d = states_used_q;
    trans_used_d  = trans_used_q;
    start_idx_d   = start_idx_q;
    start_valid_d = start_valid_q;
    cur_idx_d     = cur_idx_q;
    res_status_d  = res_status_q;
    res_next_d    = res_next_q;
    st_we         = 1'b0;
    st_we_fin     = 1'b0;
    tr_we         = 1'b0;
    if (cmd_i.apply) begin
      res_status_d = STS_ERROR;
      res_next_d   = '0;
      unique case (op_q)
        OP_ADD_NONFINAL, OP_ADD_FINAL, OP_ADD_START: begin
          if (src_hit_q) begin
            res_status_d = STS_OK;
            if (op_q == OP_ADD_START) begin
              start_idx_d   = src_idx_q;
              start_valid_d = 1'b1;
              cur_idx_d     = src_idx_q;
            end
          end else if (states_used_q != ST_CNT_W'(MAX_STATES)) begin
            st_we         = 1'b1;
            st_we_fin     = (op_q == OP_ADD_FINAL);
            states_used_d = states_used_q + ST_CNT_W'(1);
            res_status_d  = STS_OK;
            if (op_q == OP_ADD_START) begin
              start_idx_d   = states_used_q[ST_IDX_W-1:0];
              start_valid_d = 1'b1;
              cur_idx_d     = states_used_q[ST_IDX_W-1:0];
            end
          end
        end
        OP_ADD_TRANS: begin
          if (src_hit_q && dst_hit_q && (trans_used_q != TR_CNT_W'(MAX_TRANSITIONS))) begin
            tr_we        = 1'b1;
            trans_used_d = trans_used_q + TR_CNT_W'(1);
            res_status_d = STS_OK;
          end
        end
        OP_RESET: begin
          if (start_valid_q) begin
            cur_idx_d    = start_idx_q;
            res_status_d = STS_OK;
          end
        end
        OP_RUN: begin
          if (start_valid_q) begin
            if (!tr_hit_q) begin
              res_status_d = STS_NOTRANS;
            end else begin
              res_next_d = st_id_rd_q;
              if (st_fin_rd_q) begin
                cur_idx_d    = start_idx_q;
                res_status_d = STS_FINAL;
              end else begin
                cur_idx_d    = hit_dst_q;
                res_status_d = STS_OK;
              end
            end
          end
        end
        default: res_status_d = STS_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      states_used_q <= '0;
      trans_used_q  <= '0;
      start_idx_q   <= '0;
      start_valid_q <= 1'b0;
      cur_idx_q     <= '0;
      sc_q          <= '0;
      tc_q          <= '0;
      p_valid_q     <= 1'b0;
      src_hit_q     <= 1'b0;
      dst_hit_q     <= 1'b0;
      tr_hit_q      <= 1'b0;
    end else begin
      states_used_q <= states_used_d;
      trans_used_q  <= trans_used_d;
      start_idx_q   <= start_idx_d;
      start_valid_q <= start_valid_d;
      cur_idx_q     <= cur_idx_d;
      sc_q          <= sc_d;
      tc_q          <= tc_d;
      p_valid_q     <= p_valid_d;
      src_hit_q     <= src_hit_d;
      dst_hit_q     <= dst_hit_d;
      tr_hit_q      <= tr_hit_d;
    end
  end

  // Payload registers: fields, scan indexes and results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      id_q  <= state_id_i;
      sym_q <= input_symbol_i;
      dst_q <= dest_id_i;
    end
    p_idx_q      <= p_idx_d;
    src_idx_q    <= src_idx_d;
    dst_idx_q    <= dst_idx_d;
    hit_dst_q    <= hit_dst_d;
    res_status_q <= res_status_d;
    res_next_q   <= res_next_d;
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_next_q   <= res_next_q;
    end
  end

  // State table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_id_mem[states_used_q[ST_IDX_W-1:0]]  <= id_q;
      st_fin_mem[states_used_q[ST_IDX_W-1:0]] <= st_we_fin;
    end
    st_id_rd_q  <= st_id_mem[st_raddr];
    st_fin_rd_q <= st_fin_mem[st_raddr];
  end

  // Transition table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      tr_src_mem[trans_used_q[TR_IDX_W-1:0]] <= src_idx_q;
      tr_sym_mem[trans_used_q[TR_IDX_W-1:0]] <= sym_q;
      tr_dst_mem[trans_used_q[TR_IDX_W-1:0]] <= dst_idx_q;
    end
    tr_src_rd_q <= tr_src_mem[tr_raddr];
    tr_sym_rd_q <= tr_sym_mem[tr_raddr];
    tr_dst_rd_q <= tr_dst_mem[tr_raddr];
  end

endmodule

// ===== rtl/programmable_fsm_engine.sv =====
// Table-driven state machine that takes one command per input beat and
// returns one result beat per command. Commands add states, add transitions,
// return to the start state, or run one symbol. Each command is handled alone:
// add state and add transition make one pass over the state table, one entry
// per cycle, through its single read port; a run searches the transition table
// newest first, stopping at the first match, then reads the destination state
// once; reset, a run with no start state and invalid commands skip the table
// scans. A new command is accepted while the previous result still waits on
// the output.
// Tables are 16 states and 64 transitions; both are empty after reset.
module programmable_fsm_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fsme_pkg::OP_BITS-1:0]     opcode_i,
  input  logic [fsme_pkg::ID_BITS-1:0]     state_id_i,
  input  logic [fsme_pkg::SYMBOL_BITS-1:0] input_symbol_i,
  input  logic [fsme_pkg::ID_BITS-1:0]     dest_id_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fsme_pkg::STS_BITS-1:0]    status_o,
  output logic [fsme_pkg::ID_BITS-1:0]     next_id_o
);
  import fsme_pkg::*;

  fsme_cmd_t cmd;
  fsme_sts_t sts;

  fsme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsme_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .state_id_i     (state_id_i),
    .input_symbol_i (input_symbol_i),
    .dest_id_i      (dest_id_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .next_id_o      (next_id_o)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import fsme_pkg::*;

  // Opcodes the engine does not define; both must answer with an error
  localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

  localparam int RAND_ITEMS   = 650;
  localparam int BUILD_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = MAX_TRANSITIONS + 16;
  localparam int ID_POOL      = 24;
  localparam int SYM_POOL     = 6;

  typedef struct packed {
    logic [STS_BITS-1:0] sts;
    logic [ID_BITS-1:0]  nxt;
  } outcome_t;

  typedef struct packed {
    logic [OP_BITS-1:0]     op;
    logic [ID_BITS-1:0]     sid;
    logic [SYMBOL_BITS-1:0] sym;
    logic [ID_BITS-1:0]     did;
    logic                   typed;
    outcome_t               want;
  } cmd_row_t;

  localparam outcome_t ERR_R  = '{STS_ERROR, 8'h00};
  localparam outcome_t OK_R   = '{STS_OK, 8'h00};
  localparam outcome_t NONE_R = '{STS_OK, 8'h00};

  // Directed commands: empty engine errors, id extremes, duplicates,
  // newest-first matching, final states, start moves
  localparam int DIR_ROWS = 24;
  localparam cmd_row_t DIR_TBL [DIR_ROWS] = '{
    '{OP_RUN,          8'h00, 8'h00, 8'h00, 1'b1, ERR_R},
    '{OP_RESET,        8'h00, 8'h00, 8'h00, 1'b1, ERR_R},
    '{OP_SPARE_6,      8'h00, 8'h00, 8'h00, 1'b1, ERR_R},
    '{OP_SPARE_7,      8'hff, 8'hff, 8'hff, 1'b1, ERR_R},
    '{OP_ADD_TRANS,    8'hff, 8'h12, 8'h00, 1'b1, ERR_R},
    '{OP_ADD_NONFINAL, 8'h00, 8'h00, 8'h00, 1'b1, OK_R},
    '{OP_ADD_FINAL,    8'hff, 8'hff, 8'hff, 1'b1, OK_R},
    '{OP_ADD_FINAL,    8'h00, 8'h00, 8'h00, 1'b1, OK_R},
    '{OP_ADD_TRANS,    8'h00, 8'hff, 8'h77, 1'b1, ERR_R},
    '{OP_RUN,          8'h00, 8'h00, 8'h00, 1'b1, ERR_R},
    '{OP_ADD_START,    8'ha5, 8'h00, 8'h00, 1'b1, OK_R},
    '{OP_ADD_TRANS,    8'ha5, 8'h00, 8'h00, 1'b0, NONE_R},
    '{OP_ADD_TRANS,    8'h00, 8'hff, 8'hff, 1'b0, NONE_R},
    '{OP_ADD_TRANS,    8'ha5, 8'h00, 8'hff, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'h00, 8'h00, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'h5a, 8'h00, 1'b0, NONE_R},
    '{OP_ADD_TRANS,    8'ha5, 8'h5a, 8'h00, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'h5a, 8'h00, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'hff, 8'h00, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'h5a, 8'h00, 1'b0, NONE_R},
    '{OP_RESET,        8'h00, 8'h00, 8'h00, 1'b1, OK_R},
    '{OP_ADD_START,    8'h00, 8'h33, 8'h00, 1'b0, NONE_R},
    '{OP_RUN,          8'h00, 8'hff, 8'h00, 1'b0, NONE_R},
    '{OP_ADD_START,    8'ha5, 8'h00, 8'h00, 1'b0, NONE_R}
  };

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic [OP_BITS-1:0]     opcode_i       = '0;
  logic [ID_BITS-1:0]     state_id_i     = '0;
  logic [SYMBOL_BITS-1:0] input_symbol_i = '0;
  logic [ID_BITS-1:0]     dest_id_i      = '0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b0;
  logic [STS_BITS-1:0]    status_o;
  logic [ID_BITS-1:0]     next_id_o;

  // Shadow copy of the engine tables
  logic [ID_BITS-1:0]     shd_state_id [MAX_STATES];
  logic                   shd_final    [MAX_STATES];
  int                     shd_states   = 0;
  logic [ST_IDX_W-1:0]    shd_tr_src   [MAX_TRANSITIONS];
  logic [SYMBOL_BITS-1:0] shd_tr_sym   [MAX_TRANSITIONS];
  logic [ST_IDX_W-1:0]    shd_tr_dst   [MAX_TRANSITIONS];
  int                     shd_trans    = 0;
  logic [ST_IDX_W-1:0]    shd_start    = '0;
  logic [ST_IDX_W-1:0]    shd_cur      = '0;
  logic                   shd_start_ok = 1'b0;

  outcome_t               pending_outcomes [$];
  int                     fail_cnt       = 0;
  int                     send_idle_pct  = 0;
  int                     recv_stall_pct = 0;
  bit                     hold_req       = 1'b0;
  bit                     hold_taken     = 1'b0;
  int                     hold_left      = 0;
  logic [ID_BITS-1:0]     id_pool  [ID_POOL];
  logic [SYMBOL_BITS-1:0] sym_pool [SYM_POOL];

  programmable_fsm_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .state_id_i     (state_id_i),
    .input_symbol_i (input_symbol_i),
    .dest_id_i      (dest_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .next_id_o      (next_id_o)
  );

  always #2 clk_i = ~clk_i;

  // Index of a stored state id, or -1
  function automatic int find_state(input logic [ID_BITS-1:0] id);
    for (int k = 0; k < shd_states; k++) begin
      if (shd_state_id[k] == id) return k;
    end
    return -1;
  endfunction

  // Apply one command to the shadow tables and return the result it gives
  function automatic outcome_t predict_outcome(input cmd_row_t c);
    outcome_t res;
    int       idx;
    int       dst;
    res = ERR_R;
    case (c.op)
      OP_ADD_NONFINAL, OP_ADD_FINAL, OP_ADD_START: begin
        idx = find_state(c.sid);
        if (idx < 0 && shd_states < MAX_STATES) begin
          idx = shd_states;
          shd_state_id[idx] = c.sid;
          shd_final[idx]    = (c.op == OP_ADD_FINAL);
          shd_states++;
        end
        if (idx >= 0) begin
          res.sts = STS_OK;
          if (c.op == OP_ADD_START) begin
            shd_start    = ST_IDX_W'(idx);
            shd_cur      = ST_IDX_W'(idx);
            shd_start_ok = 1'b1;
          end
        end
      end
      OP_ADD_TRANS: begin
        idx = find_state(c.sid);
        dst = find_state(c.did);
        if (idx >= 0 && dst >= 0 && shd_trans < MAX_TRANSITIONS) begin
          shd_tr_src[shd_trans] = ST_IDX_W'(idx);
          shd_tr_sym[shd_trans] = c.sym;
          shd_tr_dst[shd_trans] = ST_IDX_W'(dst);
          shd_trans++;
          res.sts = STS_OK;
        end
      end
      OP_RESET: begin
        if (shd_start_ok) begin
          shd_cur = shd_start;
          res.sts = STS_OK;
        end
      end
      OP_RUN: begin
        if (shd_start_ok) begin
          res.sts = STS_NOTRANS;
          // search newest first, stop at the first match
          for (int k = shd_trans - 1; k >= 0; k--) begin
            if (shd_tr_src[k] == shd_cur && shd_tr_sym[k] == c.sym) begin
              res.nxt = shd_state_id[shd_tr_dst[k]];
              if (shd_final[shd_tr_dst[k]]) begin
                shd_cur = shd_start;
                res.sts = STS_FINAL;
              end else begin
                shd_cur = shd_tr_dst[k];
                res.sts = STS_OK;
              end
              break;
            end
          end
        end
      end
      default: res = ERR_R;
    endcase
    return res;
  endfunction

  // Offer one command beat, hold it until accepted, then queue its result
  task automatic send_cmd(input cmd_row_t c);
    outcome_t exp_r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= c.op;
    state_id_i     <= c.sid;
    input_symbol_i <= c.sym;
    dest_id_i      <= c.did;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    exp_r = predict_outcome(c);
    if (c.typed) exp_r = c.want;
    pending_outcomes.push_back(exp_r);
  endtask

  // Mostly ids from a small pool so adds, runs and duplicates meet
  function automatic logic [ID_BITS-1:0] pick_id();
    if ($urandom_range(9) == 0) return ID_BITS'($urandom);
    return id_pool[$urandom_range(ID_POOL - 1)];
  endfunction

  // Drive ready and check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        if (fail_cnt < 10)
          $display("%0t: result beat with nothing pending: status %0d next %02h",
                   $time, status_o, next_id_o);
        fail_cnt++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.sts || next_id_o !== want.nxt) begin
          if (fail_cnt < 10)
            $display("%0t: mismatch: status %0d expected %0d, next %02h expected %02h",
                     $time, status_o, want.sts, next_id_o, want.nxt);
          fail_cnt++;
        end
      end
    end
    // hold off for a long stretch once, so the engine backs up into its input
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cmd_row_t c;
    int       r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TBL[i]) send_cmd(DIR_TBL[i]);

    foreach (id_pool[i]) id_pool[i] = ID_BITS'($urandom);
    foreach (sym_pool[i]) sym_pool[i] = SYMBOL_BITS'($urandom);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // advance through the idling phases
      case (n * 4 / RAND_ITEMS)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (n == 60) hold_req = 1'b1;

      // early on favor table building, later favor runs
      r = (n < BUILD_ITEMS) ? $urandom_range(99, 30) : $urandom_range(75);
      c.sid   = pick_id();
      c.did   = pick_id();
      c.sym   = ($urandom_range(99) < 85) ? sym_pool[$urandom_range(SYM_POOL - 1)]
                                          : SYMBOL_BITS'($urandom);
      c.typed = 1'b0;
      c.want  = NONE_R;
      if (r < 40)      c.op = OP_RUN;
      else if (r < 46) c.op = OP_RESET;
      else if (r < 48) c.op = OP_SPARE_6;
      else if (r < 50) c.op = OP_SPARE_7;
      else if (r < 56) c.op = OP_ADD_START;
      else if (r < 66) c.op = OP_ADD_TRANS;
      else if (r < 76) c.op = OP_ADD_NONFINAL;
      else if (r < 84) c.op = OP_ADD_FINAL;
      else             c.op = OP_ADD_TRANS;
      send_cmd(c);
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then watch for stray beats
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
